### design/egk_pkg.sv
// Shared constants, types and helpers for the exp-Golomb order-k bit-serial decoder.
package egk_pkg;

    // Width of the internal arithmetic; every sum and shift wraps at this width.
    localparam int VALUE_BITS = 32;

    // Width of the result value field and of the order register.
    localparam int OUT_W = 32;
    localparam int K_W   = 5;

    // Counters must hold VALUE_BITS and any order value.
    localparam int CNT_RAW = $clog2(VALUE_BITS + 1);
    localparam int CNT_W   = (CNT_RAW < K_W + 1) ? K_W + 1 : CNT_RAW;

    // Decoder phase codes; the unused code behaves as prefix counting.
    localparam logic [1:0] PH_PREFIX = 2'd0;
    localparam logic [1:0] PH_WBITS  = 2'd1;
    localparam logic [1:0] PH_LOW    = 2'd2;

    // One result beat.
    typedef struct packed {
        logic [OUT_W-1:0] value;
        logic             error;
    } result_t;

    // Fit an internal value to the result field, truncating or zero-extending.
    function automatic logic [OUT_W-1:0] to_out(input logic [VALUE_BITS-1:0] v);
        logic [63:0] wide;
        wide = 64'(v);
        return wide[OUT_W-1:0];
    endfunction

endpackage

### design/egk_decode.sv
// Decoder state and the single-pass next-state and result logic for one code bit.
module egk_decode
    import egk_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  logic           code_bit,
    input  logic [K_W-1:0] order_k,
    output logic           res_valid,
    output result_t        res
);

    logic [1:0]            phase_reg, phase_next;
    logic [CNT_W-1:0]      prefix_count_reg, prefix_count_next;
    logic [CNT_W-1:0]      bits_left_reg, bits_left_next;
    logic [VALUE_BITS-1:0] w_reg, w_next;
    logic [VALUE_BITS-1:0] low_reg, low_next;

    logic [VALUE_BITS-1:0] w_shift;
    logic [VALUE_BITS-1:0] low_shift;
    logic [CNT_W-1:0]      bits_dec;
    logic [VALUE_BITS-1:0] w_src;
    logic [VALUE_BITS-1:0] low_src;
    logic [VALUE_BITS-1:0] emit_value;
    logic                  k_zero;

    assign w_shift   = {w_reg[VALUE_BITS-2:0], code_bit};
    assign low_shift = {low_reg[VALUE_BITS-2:0], code_bit};
    assign bits_dec  = bits_left_reg - CNT_W'(bits_left_reg != '0);
    assign k_zero    = (order_k == '0);

    // Accumulator values that a word ending on this bit is built from.
    always_comb
    begin
        unique case (phase_reg)
            PH_WBITS:
            begin
                w_src   = w_shift;
                low_src = low_reg;
            end
            PH_LOW:
            begin
                w_src   = w_reg;
                low_src = low_shift;
            end
            default:
            begin
                w_src   = w_reg;
                low_src = low_reg;
            end
        endcase
    end

    // Decoded value: ((w - 1) << k) + low, wrapping at the internal width.
    assign emit_value = ((w_src - VALUE_BITS'(1)) << order_k) + low_src;

    // Next state and result for the current bit.
    always_comb
    begin
        phase_next        = phase_reg;
        prefix_count_next = prefix_count_reg;
        bits_left_next    = bits_left_reg;
        w_next            = w_reg;
        low_next          = low_reg;
        res_valid         = 1'b0;
        res.value         = to_out(emit_value);
        res.error         = 1'b0;

        unique case (phase_reg)
            PH_WBITS:
            begin
                w_next         = w_shift;
                bits_left_next = bits_dec;
                if (bits_dec == '0)
                begin
                    if (!k_zero)
                    begin
                        phase_next     = PH_LOW;
                        bits_left_next = CNT_W'(order_k);
                    end
                    else
                    begin
                        res_valid = 1'b1;
                    end
                end
            end
            PH_LOW:
            begin
                low_next       = low_shift;
                bits_left_next = bits_dec;
                if (bits_dec == '0)
                begin
                    res_valid = 1'b1;
                end
            end
            default:
            begin
                if (code_bit)
                begin
                    prefix_count_next = prefix_count_reg + CNT_W'(1);
                    // Overlong prefix abandons the word.
                    if (prefix_count_reg == CNT_W'(VALUE_BITS - 1))
                    begin
                        res_valid = 1'b1;
                        res.value = '0;
                        res.error = 1'b1;
                    end
                end
                else if (prefix_count_reg != '0)
                begin
                    phase_next     = PH_WBITS;
                    bits_left_next = prefix_count_reg;
                end
                else if (!k_zero)
                begin
                    phase_next     = PH_LOW;
                    bits_left_next = CNT_W'(order_k);
                end
                else
                begin
                    res_valid = 1'b1;
                end
            end
        endcase

        // Any finished word, good or bad, restarts decoding.
        if (res_valid)
        begin
            phase_next        = PH_PREFIX;
            prefix_count_next = '0;
            bits_left_next    = '0;
            w_next            = VALUE_BITS'(1);
            low_next          = '0;
        end
    end

    // State registers advance only on a processed bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_PREFIX;
            prefix_count_reg <= '0;
            bits_left_reg    <= '0;
            w_reg            <= VALUE_BITS'(1);
            low_reg          <= '0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            prefix_count_reg <= prefix_count_next;
            bits_left_reg    <= bits_left_next;
            w_reg            <= w_next;
            low_reg          <= low_next;
        end
    end

`ifndef ASSERT_OFF
    // An error result always carries a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.error) |-> (res.value == '0))
        else $error("error result with nonzero value");

    // A finished word returns the decoder to a clean prefix phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && res_valid) |=> (phase_reg == PH_PREFIX && prefix_count_reg == '0
                                 && w_reg == VALUE_BITS'(1) && low_reg == '0))
        else $error("decoder not restarted after a word");

    // Suffix phases always have bits still to come.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_WBITS || phase_reg == PH_LOW) |-> (bits_left_reg != '0))
        else $error("suffix phase with no bits left");

    // The prefix count never reaches the overlong limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        prefix_count_reg < CNT_W'(VALUE_BITS))
        else $error("prefix count overran");
`endif

endmodule

### design/egk_out_reg.sv
// Result register that holds one decoded beat until the downstream side takes it.
module egk_out_reg
    import egk_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_data,
    output logic    free,
    output logic    m_tvalid,
    input  logic    m_tready,
    output result_t m_data
);

    logic    valid_reg;
    result_t data_reg;

    // Room for a new beat when empty or when the held beat leaves this cycle.
    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_data   = data_reg;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

`ifndef ASSERT_OFF
    // A beat is loaded only when the register has room.
    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("result register overwritten");

    // A loaded beat is presented in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        load |=> m_tvalid)
        else $error("loaded beat not presented");

    // A beat that leaves with nothing loaded behind it empties the register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !load) |=> !m_tvalid)
        else $error("taken beat presented again");
`endif

endmodule

### design/exp_golomb_k_bit_serial_decoder_unit.sv
// Top level of the exp-Golomb order-k bit-serial decoder with stream ports.
//
// Channel   Dir  Fields (low bit up)             Beat taken when
// s_*       in   tdata[0] code_bit               s_tvalid && s_tready
// m_*       out  tdata[31:0] value, tuser error  m_tvalid && m_tready
// cfg_*     in   cfg_wr_data order_k             cfg_wr_en
//
// One code bit per clock while the result register has room: a bit waits in the
// input register, then the decode logic updates the state and loads the result
// register in one pass; a word's result is presented from the result register.
// Reset clears the decoder to the prefix phase and order_k to zero; no sweep.
// While a result waits, one more bit is taken into the input register.
module exp_golomb_k_bit_serial_decoder_unit
    import egk_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,     // [0] code_bit, [7:1] zero
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [31:0]    m_tdata,     // [31:0] value
    output logic [0:0]     m_tuser,     // [0] error
    input  logic           cfg_wr_en,
    input  logic [K_W-1:0] cfg_wr_data
);

    logic           in_valid_reg;
    logic           in_bit_reg;
    logic [K_W-1:0] order_k_reg;
    logic           advance;
    logic           out_free;
    logic           res_valid;
    result_t        res;
    result_t        out_data;

    // A held bit is processed whenever the result register has room.
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    // Input register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_bit_reg <= s_tdata[0];
        end
    end

    // Order register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_k_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            order_k_reg <= cfg_wr_data;
        end
    end

    egk_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .code_bit  (in_bit_reg),
        .order_k   (order_k_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    egk_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && res_valid),
        .load_data (res),
        .free      (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_data    (out_data)
    );

    assign m_tdata = out_data.value;
    assign m_tuser = out_data.error;

`ifndef ASSERT_OFF
    // A held bit that cannot advance stays in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("held bit dropped");

    // The input side is refused only while a bit waits on a full result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && m_tvalid && !m_tready))
        else $error("input stalled without cause");

    // A result beat that is not taken stays on the port unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result beat changed");
`endif

endmodule
